/* design/brb_pkg.sv */
package brb_pkg;

   localparam int DEPTH_DEFAULT   = 1024;
   localparam int MAX_RUN_DEFAULT = 64;

   localparam int REQ_CODE_W = 3;
   localparam int BYTE_W     = 8;
   localparam int RUN_W      = 7;
   localparam int COUNT_W    = 10;

   localparam logic [REQ_CODE_W-1:0] REQ_PUSH  = 3'd0;
   localparam logic [REQ_CODE_W-1:0] REQ_POP   = 3'd1;
   localparam logic [REQ_CODE_W-1:0] REQ_PEEK  = 3'd2;
   localparam logic [REQ_CODE_W-1:0] REQ_SKIP  = 3'd3;
   localparam logic [REQ_CODE_W-1:0] REQ_CLEAR = 3'd4;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic [REQ_CODE_W-1:0] req_type;
      logic [BYTE_W-1:0]     data_byte;
      logic [RUN_W-1:0]      run_length;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic               status;
      logic               last;
      logic [COUNT_W-1:0] used_count;
      logic [COUNT_W-1:0] free_count;
   } rsp_word_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } brb_state_type;

endpackage

/* design/byte_ring_buffer.sv */
// Channel | Direction | Handshake            | Word
// req     | in        | req_valid, req_stall | brb_pkg::req_word_type
// rsp     | out       | rsp_valid, rsp_stall | brb_pkg::rsp_word_type
//
// Push, skip, clear, a zero-length run and every rejection give one word. Pop and
// peek of N bytes give N words, one per cycle while rsp_stall is low, paced by the
// single registered read port of the byte store.
// Reset (synchronous) zeroes both indices and the fill level; the store keeps
// its contents and needs no clearing pass.
// rsp_stall holds the output register; the read stage then waits behind it.
module byte_ring_buffer #(
   parameter int DEPTH   = brb_pkg::DEPTH_DEFAULT,
   parameter int MAX_RUN = brb_pkg::MAX_RUN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  brb_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output brb_pkg::rsp_word_type rsp_word
);
   import brb_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int SW = ((IW > RUN_W) ? IW : RUN_W) + 1;

   localparam logic [IW-1:0]    LAST_SLOT = IW'(DEPTH - 1);
   localparam logic [SW-1:0]    DEPTH_S   = SW'(DEPTH);
   localparam logic [RUN_W-1:0] MAX_RUN_R = RUN_W'(MAX_RUN);

   function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                              input logic [RUN_W-1:0] step);
      logic [SW-1:0] sum;
      logic [SW-1:0] wrapped;
      sum = SW'(idx) + SW'(step);
      wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
      return wrapped[IW-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] to_count(input logic [IW-1:0] v);
      logic [IW+COUNT_W-1:0] wide;
      wide = {{COUNT_W{1'b0}}, v};
      return wide[COUNT_W-1:0];
   endfunction

   logic [BYTE_W-1:0] mem_q [DEPTH];

   brb_state_type     state_ff, state_in;
   logic [IW-1:0]     rd_idx_ff, rd_idx_in;
   logic [IW-1:0]     wr_idx_ff, wr_idx_in;
   logic [IW-1:0]     fill_ff, fill_in;
   logic [IW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [RUN_W-1:0]  left_ff, left_in;
   logic              mem_vld_ff, mem_vld_in;
   logic              mem_last_ff;
   logic [BYTE_W-1:0] mem_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              out_ready;
   logic              req_fire;
   logic              mem_move;
   logic              rd_en;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic              run_ok;
   logic              run_start;
   logic              single_fire;
   logic              single_status;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_ready);
   assign req_fire  = req_valid && !req_stall;
   assign mem_move  = mem_vld_ff && out_ready;
   assign rd_en     = (state_ff == ST_RUN) && (left_ff != '0) && (!mem_vld_ff || mem_move);
   assign run_ok    = (req_word.run_length <= MAX_RUN_R) &&
                      (SW'(req_word.run_length) <= SW'(fill_ff));
   assign wr_addr   = advance(wr_idx_ff, RUN_W'(1));

   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      fill_in       = fill_ff;
      rd_ptr_in     = rd_ptr_ff;
      left_in       = left_ff;
      wr_en         = 1'b0;
      run_start     = 1'b0;
      single_fire   = 1'b0;
      single_status = STATUS_OK;

      if (req_fire) begin
         single_fire = 1'b1;
         unique case (req_word.req_type)
            REQ_PUSH: begin
               if (fill_ff == LAST_SLOT) begin
                  single_status = STATUS_REJECT;
               end else begin
                  wr_en     = 1'b1;
                  wr_idx_in = wr_addr;
                  fill_in   = fill_ff + IW'(1);
               end
            end
            REQ_POP, REQ_PEEK, REQ_SKIP: begin
               if (!run_ok) begin
                  single_status = STATUS_REJECT;
               end else begin
                  if (req_word.req_type != REQ_PEEK) begin
                     rd_idx_in = advance(rd_idx_ff, req_word.run_length);
                     fill_in   = fill_ff - IW'(req_word.run_length);
                  end
                  if ((req_word.req_type != REQ_SKIP) && (req_word.run_length != '0)) begin
                     run_start   = 1'b1;
                     single_fire = 1'b0;
                     rd_ptr_in   = advance(rd_idx_ff, RUN_W'(1));
                     left_in     = req_word.run_length;
                     state_in    = ST_RUN;
                  end
               end
            end
            REQ_CLEAR: begin
               rd_idx_in = '0;
               wr_idx_in = '0;
               fill_in   = '0;
            end
            default: begin
               single_status = STATUS_REJECT;
            end
         endcase
      end

      if (rd_en) begin
         rd_ptr_in = advance(rd_ptr_ff, RUN_W'(1));
         left_in   = left_ff - RUN_W'(1);
      end

      // return to idle once the final byte reaches the output register
      if ((state_ff == ST_RUN) && mem_move && mem_last_ff) begin
         state_in = ST_IDLE;
      end

      if (rd_en) begin
         mem_vld_in = 1'b1;
      end else if (mem_move) begin
         mem_vld_in = 1'b0;
      end else begin
         mem_vld_in = mem_vld_ff;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_ready) begin
         rsp_valid_in           = single_fire || mem_move;
         rsp_word_in.out_byte   = mem_move ? mem_data_ff : '0;
         rsp_word_in.status     = mem_move ? STATUS_OK : single_status;
         rsp_word_in.last       = mem_move ? mem_last_ff : 1'b1;
         rsp_word_in.used_count = to_count(fill_in);
         rsp_word_in.free_count = to_count(LAST_SLOT - fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         fill_ff      <= '0;
         left_ff      <= '0;
         mem_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         fill_ff      <= fill_in;
         left_ff      <= left_in;
         mem_vld_ff   <= mem_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      rsp_word_ff <= rsp_word_in;
   end

   // byte store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_q[wr_addr] <= req_word.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_data_ff <= mem_q[rd_ptr_ff];
         mem_last_ff <= (left_ff == RUN_W'(1));
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LAST_SLOT)
      else $error("fill level above capacity");

   a_read_stage_in_run: assert property (@(posedge clock) disable iff (reset)
      mem_vld_ff |-> (state_ff == ST_RUN))
      else $error("read stage holds a byte outside a run");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (mem_vld_ff && !out_ready) |-> !rd_en)
      else $error("read issued over an unmoved byte");

   a_fill_held_in_run: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && $past(state_ff == ST_RUN)) |-> $stable(fill_ff))
      else $error("fill level changed during a run");

   a_run_start_idle: assert property (@(posedge clock) disable iff (reset)
      run_start |=> (state_ff == ST_RUN) && (left_ff != '0))
      else $error("run did not start");

endmodule

/* tb/byte_ring_buffer_checker.sv */
module byte_ring_buffer_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  brb_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  brb_pkg::rsp_word_type rsp_word,
   output int                    fail_count,
   output int                    words_due
);

   import brb_pkg::*;

   localparam int RING_DEPTH = DEPTH_DEFAULT;
   localparam int RUN_MAX    = MAX_RUN_DEFAULT;

   logic [BYTE_W-1:0] ring_store [RING_DEPTH];
   int unsigned       rd_ptr;
   int unsigned       wr_ptr;
   int unsigned       byte_count;

   rsp_word_type      due_words [$];
   rsp_word_type      want;

   initial begin
      fail_count = 0;
      words_due  = 0;
      rd_ptr     = 0;
      wr_ptr     = 0;
      byte_count = 0;
   end

   // counts always reflect the state after the request
   function automatic rsp_word_type result_word(input logic [BYTE_W-1:0] b, input logic st,
                                                input logic lst);
      rsp_word_type r;
      r.out_byte   = b;
      r.status     = st;
      r.last       = lst;
      r.used_count = COUNT_W'(byte_count);
      r.free_count = COUNT_W'(RING_DEPTH - 1 - byte_count);
      return r;
   endfunction

   task automatic ring_step(input req_word_type w);
      logic [BYTE_W-1:0] run_bytes [RUN_MAX];
      int unsigned       n;
      n = w.run_length;
      case (w.req_type)
         REQ_PUSH: begin
            if (byte_count >= RING_DEPTH - 1) begin
               due_words.push_back(result_word('0, STATUS_REJECT, 1'b1));
            end else begin
               wr_ptr = (wr_ptr + 1) % RING_DEPTH;
               ring_store[wr_ptr] = w.data_byte;
               byte_count++;
               due_words.push_back(result_word('0, STATUS_OK, 1'b1));
            end
         end
         REQ_POP, REQ_PEEK: begin
            if (n > RUN_MAX || n > byte_count) begin
               due_words.push_back(result_word('0, STATUS_REJECT, 1'b1));
            end else if (n == 0) begin
               due_words.push_back(result_word('0, STATUS_OK, 1'b1));
            end else begin
               for (int i = 0; i < n; i++) begin
                  run_bytes[i] = ring_store[(rd_ptr + i + 1) % RING_DEPTH];
               end
               // a pop commits before its words go out, so every word carries the new counts
               if (w.req_type == REQ_POP) begin
                  rd_ptr     = (rd_ptr + n) % RING_DEPTH;
                  byte_count = byte_count - n;
               end
               for (int i = 0; i < n; i++) begin
                  due_words.push_back(result_word(run_bytes[i], STATUS_OK, i + 1 == n));
               end
            end
         end
         REQ_SKIP: begin
            if (n > RUN_MAX || n > byte_count) begin
               due_words.push_back(result_word('0, STATUS_REJECT, 1'b1));
            end else begin
               rd_ptr     = (rd_ptr + n) % RING_DEPTH;
               byte_count = byte_count - n;
               due_words.push_back(result_word('0, STATUS_OK, 1'b1));
            end
         end
         REQ_CLEAR: begin
            rd_ptr     = 0;
            wr_ptr     = 0;
            byte_count = 0;
            due_words.push_back(result_word('0, STATUS_OK, 1'b1));
         end
         default: begin
            due_words.push_back(result_word('0, STATUS_REJECT, 1'b1));
         end
      endcase
   endtask

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rd_ptr     = 0;
         wr_ptr     = 0;
         byte_count = 0;
         due_words.delete();
      end else begin
         if (req_valid && !req_stall) begin
            ring_step(req_word);
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               $display("%0t: word with nothing expected, actual %h", $time, rsp_word);
               fail_count++;
            end else begin
               want = due_words.pop_front();
               check_field("out_byte", want.out_byte, rsp_word.out_byte);
               check_field("status", want.status, rsp_word.status);
               check_field("last", want.last, rsp_word.last);
               check_field("used_count", want.used_count, rsp_word.used_count);
               check_field("free_count", want.free_count, rsp_word.free_count);
            end
         end
      end
      words_due = due_words.size();
   end

endmodule

/* tb/byte_ring_buffer_tb.sv */
module byte_ring_buffer_tb;

   import brb_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 400;
   localparam int FULL_LEVEL  = DEPTH_DEFAULT - 1;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   int           fail_count;
   int           words_due;
   int           cycle_count = 0;
   int           burst_left  = 0;
   int           items_sent  = 0;
   bit           no_gaps     = 1'b0;
   logic         hold_off_go = 1'b0;

   byte_ring_buffer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   byte_ring_buffer_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .words_due  (words_due)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // offer one word; gaps fall between bursts of random length
   task automatic offer(input logic [REQ_CODE_W-1:0] code, input int data, input int run);
      req_word_type w;
      int           gap;
      w.req_type   = code;
      w.data_byte  = BYTE_W'(data);
      w.run_length = RUN_W'(run);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (no_gaps) gap = 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic offer_read(input int run);
      case ($urandom_range(0, 2))
         0:       offer(REQ_POP, $urandom_range(0, 255), run);
         1:       offer(REQ_PEEK, $urandom_range(0, 255), run);
         default: offer(REQ_SKIP, $urandom_range(0, 255), run);
      endcase
   endtask

   task automatic push_random();
      offer(REQ_PUSH, $urandom_range(0, 255), $urandom_range(0, 127));
   endtask

   // receiver: segments of different stall density, plus one long hold-off
   initial begin
      int seg_left;
      int mode;
      int hold_left;
      bit hold_done;
      rsp_stall = 1'b0;
      seg_left  = 0;
      mode      = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(8, 80);
            mode     = $urandom_range(0, 3);
         end
         seg_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 4) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin
      int pick;
      int run;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty buffer, zero runs, extremes, oversize runs, unknown codes
      offer(REQ_POP, 8'h00, 1);
      offer(REQ_PEEK, 8'hFF, 0);
      offer(REQ_SKIP, 8'h00, 0);
      offer(REQ_POP, 8'hFF, 0);
      offer(REQ_SKIP, 8'h00, 1);
      offer(REQ_PUSH, 8'h00, 0);
      offer(REQ_PUSH, 8'hFF, 127);
      offer(REQ_PUSH, 8'hA5, 0);
      offer(REQ_PUSH, 8'h5A, 127);
      offer(REQ_PEEK, 8'h00, 4);
      offer(REQ_PEEK, 8'h00, 5);
      offer(REQ_POP, 8'h00, 2);
      offer(REQ_SKIP, 8'hFF, 1);
      offer(REQ_POP, 8'h00, 1);
      offer(REQ_PUSH, 8'h81, 0);
      offer(REQ_POP, 8'h00, MAX_RUN_DEFAULT + 1);
      offer(REQ_PEEK, 8'h00, 127);
      offer(REQ_SKIP, 8'h00, 127);
      for (int c = REQ_CLEAR + 1; c < (1 << REQ_CODE_W); c++) begin
         offer(REQ_CODE_W'(c), $urandom_range(0, 255), $urandom_range(0, 127));
      end
      offer(REQ_CLEAR, 8'hFF, 127);
      offer(REQ_PUSH, 8'h3C, 0);
      offer(REQ_POP, 8'h00, 1);

      // fill to the top, overflow, then refill across the wrap under a long hold-off
      offer(REQ_CLEAR, 8'h00, 0);
      repeat (FULL_LEVEL) push_random();
      repeat (2) push_random();
      offer(REQ_PEEK, 8'h00, MAX_RUN_DEFAULT);
      offer(REQ_POP, 8'h00, MAX_RUN_DEFAULT);
      offer(REQ_SKIP, 8'h00, MAX_RUN_DEFAULT);
      no_gaps     = 1'b1;
      hold_off_go = 1'b1;
      repeat (2 * MAX_RUN_DEFAULT + 2) push_random();
      no_gaps = 1'b0;
      offer(REQ_POP, 8'h00, MAX_RUN_DEFAULT + 1);
      repeat (15) offer(REQ_POP, $urandom_range(0, 255), MAX_RUN_DEFAULT);
      offer(REQ_SKIP, 8'h00, MAX_RUN_DEFAULT - 1);
      offer(REQ_POP, 8'h00, 1);

      // random: mostly push bursts followed by short reads, with some noise
      items_sent = 0;
      while (items_sent < 210) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            offer(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 127));
         end else if (pick == 1) begin
            offer(REQ_CODE_W'(REQ_CLEAR + $urandom_range(1, 3)), $urandom_range(0, 255),
                  $urandom_range(0, 127));
         end else begin
            repeat ($urandom_range(1, 20)) push_random();
            repeat ($urandom_range(1, 4)) begin
               run = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 12);
               offer_read(run);
            end
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (words_due != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
